// ===== sv/slm_pkg.sv =====
// Shared types, constants and sine table for the slew-limited omni wheel mixer.
// Used by every module of the block; depends on nothing.
package slm_pkg;

  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned ENC_W      = 13;
  localparam int unsigned STEP_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned MUL_W      = 18;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 52;
  localparam int unsigned WHEEL_SH   = 26;
  localparam int unsigned QUO_W      = 15;
  localparam int unsigned DVD_W      = 31;

  localparam logic [STEP_W-1:0]  RST_STEP_XY   = 15'd15;
  localparam logic [STEP_W-1:0]  RST_STEP_SPIN = 15'd80;
  localparam logic [GAIN_W-1:0]  RST_GAIN      = 16'd4096;
  localparam logic [STEP_W-1:0]  RST_LIMIT     = 15'd2500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X    = 3'd0,
    REG_STEP_Y    = 3'd1,
    REG_STEP_SPIN = 3'd2,
    REG_YAW_CTR   = 3'd3,
    REG_TURN_DIR  = 3'd4,
    REG_DIAG_GAIN = 3'd5,
    REG_SPIN_GAIN = 3'd6,
    REG_WHEEL_LIM = 3'd7
  } cfg_reg_e;

  // Operations of the shared multiplier, in the order the sequencer issues them.
  typedef enum logic [3:0] {
    MOP_SIN = 4'd0,
    MOP_COS = 4'd1,
    MOP_XSN = 4'd2,
    MOP_YSN = 4'd3,
    MOP_XCS = 4'd4,
    MOP_YCS = 4'd5,
    MOP_DXL = 4'd6,
    MOP_DXH = 4'd7,
    MOP_DYL = 4'd8,
    MOP_DYH = 4'd9,
    MOP_SPN = 4'd10,
    MOP_LIM = 4'd11
  } mop_e;

  localparam logic [3:0] MOP_LAST = 4'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP,
    ST_MUL,
    ST_WHEEL,
    ST_MAX,
    ST_LMUL,
    ST_LSTART,
    ST_LDIV,
    ST_OUT
  } state_e;

  // Quarter-wave sine in Q14, 17 points.
  function automatic logic [14:0] sine_tab(input logic [4:0] idx);
    logic [14:0] v;
    unique case (idx)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd1606;
      5'd2:  v = 15'd3196;
      5'd3:  v = 15'd4756;
      5'd4:  v = 15'd6270;
      5'd5:  v = 15'd7723;
      5'd6:  v = 15'd9102;
      5'd7:  v = 15'd10394;
      5'd8:  v = 15'd11585;
      5'd9:  v = 15'd12665;
      5'd10: v = 15'd13623;
      5'd11: v = 15'd14449;
      5'd12: v = 15'd15137;
      5'd13: v = 15'd15679;
      5'd14: v = 15'd16069;
      5'd15: v = 15'd16305;
      5'd16: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Position within the quarter wave: odd quadrants run backward.
  function automatic logic [14:0] quarter_x(input logic [1:0] q, input logic [13:0] w);
    return q[0] ? (15'd16384 - {1'b0, w}) : {1'b0, w};
  endfunction

  function automatic logic [14:0] quarter_base(input logic [14:0] x);
    return x[14] ? 15'd16384 : sine_tab({1'b0, x[13:10]});
  endfunction

  function automatic logic [10:0] quarter_diff(input logic [14:0] x);
    logic [14:0] d;
    d = sine_tab({1'b0, x[13:10]} + 5'd1) - sine_tab({1'b0, x[13:10]});
    return x[14] ? 11'd0 : d[10:0];
  endfunction

endpackage

// ===== sv/slm_if.sv =====
// Valid/ready channel interfaces for the mixer's target and wheel beats.
// No dependencies.
interface slm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_spin;
  logic        [12:0] yaw_encoder;

  modport source (output valid, target_x, target_y, target_spin, yaw_encoder,
                  input ready);
  modport sink (input valid, target_x, target_y, target_spin, yaw_encoder,
                output ready);
endinterface

interface slm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_0;
  logic signed [15:0] wheel_1;
  logic signed [15:0] wheel_2;
  logic signed [15:0] wheel_3;
  logic               was_scaled;

  modport source (output valid, wheel_0, wheel_1, wheel_2, wheel_3, was_scaled,
                  input ready);
  modport sink (input valid, wheel_0, wheel_1, wheel_2, wheel_3, was_scaled,
                output ready);
endinterface

// ===== sv/slm_mul.sv =====
// Shared 18x18 signed multiplier with a registered product and operation tag.
// Depends on slm_pkg.
module slm_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  slm_pkg::mop_e                         tag_i,
  input  logic signed [slm_pkg::MUL_W-1:0]      a_i,
  input  logic signed [slm_pkg::MUL_W-1:0]      b_i,
  output logic                                  vld_o,
  output slm_pkg::mop_e                         tag_o,
  output logic signed [slm_pkg::PROD_W-1:0]     prod_o
);
  import slm_pkg::*;

  logic                     vld_q;
  mop_e                     tag_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      prod_q <= a_i * b_i;
    end
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign prod_o = prod_q;

endmodule

// ===== sv/slm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the wheel limit scaling.
// The dividend must be below divisor * 2^15. Depends on slm_pkg.
module slm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slm_pkg::DVD_W-1:0]     dividend_i,
  input  logic [slm_pkg::SPEED_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [slm_pkg::QUO_W-1:0]     quot_o
);
  import slm_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [3:0]          cnt_q;
  logic [SPEED_W-1:0]  rem_q;
  logic [SPEED_W-1:0]  dsr_q;
  logic [QUO_W-1:0]    low_q;
  logic [QUO_W-1:0]    quo_q;
  logic [SPEED_W:0]    trial;
  logic                fits;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DVD_W-1:QUO_W];
      low_q <= dividend_i[QUO_W-1:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? SPEED_W'(trial - {1'b0, dsr_q}) : trial[SPEED_W-1:0];
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/slew_limited_omni_wheel_mixer.sv =====
// Slew-limited omni wheel mixer: one target beat in, one beat of four wheel
// speeds out. Target beats arrive on in_if (x, y, spin and the yaw encoder
// count); wheel beats leave on out_if. Both are valid/ready channels.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) and
// must only be written while the block is idle.
// One beat at a time: in_if.ready is high only while idle. A beat is ramped,
// rotated and mixed by a sequencer around one shared 18x18 multiplier. When a
// wheel exceeds the limit, each wheel takes one more multiply and a restoring
// division.
// The result waits in the output register while out_if.ready is low; no new
// beat is taken until it has been delivered.
// Reset clears the ramped velocities and restores the register defaults.
// Depends on slm_pkg, slm_if, slm_mul and slm_div.
module slew_limited_omni_wheel_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  slm_in_if.sink                            in_if,
  slm_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [slm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [slm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import slm_pkg::*;

  // Configuration registers.
  logic [STEP_W-1:0]  step_x_q, step_y_q, step_s_q, limit_q;
  logic [ENC_W-1:0]   yaw_ctr_q;
  logic               turn_q;
  logic [GAIN_W-1:0]  dgain_q, sgain_q;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  logic signed [SPEED_W-1:0] tx_q, ty_q, ts_q;
  logic [ENC_W-1:0]          enc_q;
  logic signed [SPEED_W-1:0] rx_q, ry_q, rs_q;
  logic [PHASE_W-1:0]        phase_q;
  logic signed [15:0]        sn_q, cs_q;
  logic signed [31:0]        xc_q, yc_q;
  logic signed [ACC_W-1:0]   a_q, b_q, s_q;
  logic signed [SPEED_W-1:0] w_q [4];
  logic [SPEED_W-1:0]        m_q;
  logic                      scaled_q;
  logic                      psign_q;

  logic                      mul_en;
  mop_e                      mul_tag;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic                      pv;
  mop_e                      ptag;
  logic signed [PROD_W-1:0]  prod;

  logic                      div_start, div_done;
  logic [QUO_W-1:0]          quot;
  logic [DVD_W-1:0]          prod_mag;

  logic                      over;
  logic [1:0]                widx;

  assign widx = cnt_q[1:0];
  assign over = m_q > {1'b0, limit_q};

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q  <= RST_STEP_XY;
      step_y_q  <= RST_STEP_XY;
      step_s_q  <= RST_STEP_SPIN;
      yaw_ctr_q <= '0;
      turn_q    <= 1'b0;
      dgain_q   <= RST_GAIN;
      sgain_q   <= RST_GAIN;
      limit_q   <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_X:    step_x_q  <= cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:    step_y_q  <= cfg_data_i[STEP_W-1:0];
        REG_STEP_SPIN: step_s_q  <= cfg_data_i[STEP_W-1:0];
        REG_YAW_CTR:   yaw_ctr_q <= cfg_data_i[ENC_W-1:0];
        REG_TURN_DIR:  turn_q    <= cfg_data_i[0];
        REG_DIAG_GAIN: dgain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_SPIN_GAIN: sgain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_WHEEL_LIM: limit_q   <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) state_d = ST_RAMP;
      end
      ST_RAMP: begin
        state_d = ST_MUL;
        cnt_d   = '0;
      end
      ST_MUL: begin
        // The count runs past MOP_LAST with no multiply issued, so the last product lands in its accumulator.
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == MOP_LAST + 4'd1) begin
          state_d = ST_WHEEL;
          cnt_d   = '0;
        end
      end
      ST_WHEEL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = ST_MAX;
          cnt_d   = '0;
        end
      end
      ST_MAX: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = ST_LMUL;
          cnt_d   = '0;
        end
      end
      ST_LMUL: begin
        state_d = over ? ST_LSTART : ST_OUT;
      end
      ST_LSTART: begin
        state_d = ST_LDIV;
      end
      ST_LDIV: begin
        if (div_done) begin
          if (cnt_q == 4'd3) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_LMUL;
            cnt_d   = cnt_q + 4'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_if.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready  = state_q == ST_IDLE;
    out_if.valid = state_q == ST_OUT;
    mul_en       = 1'b0;
    mul_tag      = MOP_LIM;
    div_start    = state_q == ST_LSTART;
    if (state_q == ST_MUL && cnt_q <= MOP_LAST) begin
      mul_en  = 1'b1;
      mul_tag = mop_e'(cnt_q);
    end else if (state_q == ST_LMUL && over) begin
      mul_en  = 1'b1;
      mul_tag = MOP_LIM;
    end
  end

  // ---------------- shared multiplier operands ----------------
  logic [1:0]  q_sin, q_cos;
  logic [14:0] x_sin, x_cos;

  assign q_sin = phase_q[15:14];
  assign q_cos = phase_q[15:14] + 2'd1;
  assign x_sin = quarter_x(q_sin, phase_q[13:0]);
  assign x_cos = quarter_x(q_cos, phase_q[13:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mul_tag)
      MOP_SIN: begin
        mul_a = MUL_W'(quarter_diff(x_sin));
        mul_b = MUL_W'(x_sin[9:0]);
      end
      MOP_COS: begin
        mul_a = MUL_W'(quarter_diff(x_cos));
        mul_b = MUL_W'(x_cos[9:0]);
      end
      MOP_XSN: begin mul_a = MUL_W'(rx_q); mul_b = MUL_W'(sn_q); end
      MOP_YSN: begin mul_a = MUL_W'(ry_q); mul_b = MUL_W'(sn_q); end
      MOP_XCS: begin mul_a = MUL_W'(rx_q); mul_b = MUL_W'(cs_q); end
      MOP_YCS: begin mul_a = MUL_W'(ry_q); mul_b = MUL_W'(cs_q); end
      MOP_DXL: begin
        mul_a = MUL_W'({1'b0, dgain_q});
        mul_b = MUL_W'({1'b0, xc_q[15:0]});
      end
      MOP_DXH: begin
        mul_a = MUL_W'({1'b0, dgain_q});
        mul_b = MUL_W'($signed(xc_q[31:16]));
      end
      MOP_DYL: begin
        mul_a = MUL_W'({1'b0, dgain_q});
        mul_b = MUL_W'({1'b0, yc_q[15:0]});
      end
      MOP_DYH: begin
        mul_a = MUL_W'({1'b0, dgain_q});
        mul_b = MUL_W'($signed(yc_q[31:16]));
      end
      MOP_SPN: begin mul_a = MUL_W'({1'b0, sgain_q}); mul_b = MUL_W'(rs_q); end
      MOP_LIM: begin mul_a = MUL_W'(w_q[widx]); mul_b = MUL_W'({1'b0, limit_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  slm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .tag_i  (mul_tag),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .vld_o  (pv),
    .tag_o  (ptag),
    .prod_o (prod)
  );

  assign prod_mag = prod[PROD_W-1] ? DVD_W'(-prod) : DVD_W'(prod);

  slm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag),
    .divisor_i  (m_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // ---------------- ramp and angle ----------------
  function automatic logic signed [SPEED_W-1:0] ramp_to(
    input logic signed [SPEED_W-1:0] tgt,
    input logic signed [SPEED_W-1:0] cur,
    input logic [STEP_W-1:0]         step
  );
    logic signed [SPEED_W:0] err, lim;
    err = {tgt[SPEED_W-1], tgt} - {cur[SPEED_W-1], cur};
    lim = {2'b00, step};
    if (err > lim) err = lim;
    else if (err < -lim) err = -lim;
    return SPEED_W'({cur[SPEED_W-1], cur} + err);
  endfunction

  logic [ENC_W-1:0] ang;
  assign ang = turn_q ? (yaw_ctr_q - enc_q) : (enc_q - yaw_ctr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q <= '0;
      ry_q <= '0;
      rs_q <= '0;
    end else if (state_q == ST_RAMP) begin
      rx_q <= ramp_to(tx_q, rx_q, step_x_q);
      ry_q <= ramp_to(ty_q, ry_q, step_y_q);
      rs_q <= ramp_to(ts_q, rs_q, step_s_q);
    end
  end

  // ---------------- accumulators and wheels ----------------
  logic [14:0]               mag_sin, mag_cos;
  logic signed [ACC_W-1:0]   pw, pw16;
  logic signed [ACC_W-1:0]   wsel, wsum;
  logic signed [ACC_W-WHEEL_SH-1:0] wq;
  logic signed [SPEED_W-1:0] wsat;
  logic [SPEED_W-1:0]        wabs;

  assign mag_sin = quarter_base(x_sin) + 15'(prod[20:10]);
  assign mag_cos = quarter_base(x_cos) + 15'(prod[20:10]);
  assign pw      = ACC_W'(prod);
  assign pw16    = pw <<< 16;

  assign wsel = cnt_q[0] ? b_q : a_q;
  assign wsum = cnt_q[1] ? (s_q + wsel) : (s_q - wsel);

  always_comb begin
    // Truncate toward zero, then saturate to the speed range.
    wq = (ACC_W - WHEEL_SH)'(wsum >>> WHEEL_SH);
    if (wsum[ACC_W-1] && (wsum[WHEEL_SH-1:0] != '0)) wq = wq + 1'b1;
    if (wq > (ACC_W - WHEEL_SH)'(32767)) wsat = 16'sh7fff;
    else if (wq < -(ACC_W - WHEEL_SH)'(32768)) wsat = 16'sh8000;
    else wsat = wq[SPEED_W-1:0];
  end

  assign wabs = w_q[widx][SPEED_W-1] ? SPEED_W'(-w_q[widx]) : w_q[widx];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      tx_q  <= in_if.target_x;
      ty_q  <= in_if.target_y;
      ts_q  <= in_if.target_spin;
      enc_q <= in_if.yaw_encoder;
    end
    if (state_q == ST_RAMP) phase_q <= {ang, 3'b000};
    if (pv) begin
      unique case (ptag)
        MOP_SIN: sn_q <= q_sin[1] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
        MOP_COS: cs_q <= q_cos[1] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
        MOP_XSN: yc_q <= prod[31:0];
        MOP_YSN: xc_q <= -prod[31:0];
        MOP_XCS: xc_q <= xc_q + prod[31:0];
        MOP_YCS: yc_q <= yc_q + prod[31:0];
        MOP_DXL: begin a_q <= pw;          b_q <= pw;          end
        MOP_DXH: begin a_q <= a_q + pw16;  b_q <= b_q + pw16;  end
        MOP_DYL: begin a_q <= a_q + pw;    b_q <= b_q - pw;    end
        MOP_DYH: begin a_q <= a_q + pw16;  b_q <= b_q - pw16;  end
        MOP_SPN: s_q <= pw <<< 14;
        MOP_LIM: ;
        default: ;
      endcase
    end
    if (state_q == ST_MUL && cnt_q == MOP_LAST + 4'd1) m_q <= '0;
    if (state_q == ST_WHEEL) w_q[widx] <= wsat;
    if (state_q == ST_MAX && wabs > m_q) m_q <= wabs;
    if (state_q == ST_LMUL && cnt_q == 4'd0) scaled_q <= over;
    if (state_q == ST_LSTART) psign_q <= prod[PROD_W-1];
    if (state_q == ST_LDIV && div_done) begin
      w_q[widx] <= psign_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
  end

  assign out_if.wheel_0    = w_q[0];
  assign out_if.wheel_1    = w_q[1];
  assign out_if.wheel_2    = w_q[2];
  assign out_if.wheel_3    = w_q[3];
  assign out_if.was_scaled = scaled_q;

  // ---------------- assertions ----------------
  a_no_take_while_holding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input taken while a result is pending");

  a_accept_starts_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q == ST_RAMP))
    else $error("accepted beat did not start the sequence");

  a_unscaled_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.was_scaled) |-> (m_q <= {1'b0, limit_q}))
    else $error("unscaled result exceeds wheel limit");

  a_div_only_when_scaling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> over)
    else $error("division started without limit overrun");

endmodule
